/* hw/rtl/fcr_pkg.sv */
// ----------------------------------------------------------------------------
// FAT16 cluster chain reader package
// Shared widths, codes, configuration/item/result types of the chain reader.
// ----------------------------------------------------------------------------
package fcr_pkg;

   localparam int unsigned SECTOR_BYTES      = 512;
   localparam int unsigned SECTOR_SHIFT      = $clog2(SECTOR_BYTES);
   localparam int unsigned SPC_W             = 8;
   localparam int unsigned LBA_W             = 32;
   localparam int unsigned CLUSTER_W         = 16;
   localparam int unsigned BYTES_W           = 32;
   localparam int unsigned COPY_W            = 17;
   localparam int unsigned OFFSET_W          = 9;
   localparam int unsigned CSR_INDEX_W       = 2;
   localparam int unsigned CSR_DATA_W        = 32;
   // Raw cluster size before saturation: sectors times sector bytes.
   localparam int unsigned CSIZE_W           = SPC_W + SECTOR_SHIFT;
   localparam int unsigned MAX_CLUSTER_BYTES = 65536;

   localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 16'd2;
   localparam logic [CLUSTER_W-1:0] END_CLUSTER        = 16'hFFF8;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_REPLY = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SECTORS_PER_CLUSTER = 2'd0,
      CSR_FAT_START_LBA       = 2'd1,
      CSR_DATA_START_LBA      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SPC_W-1:0] sectors_per_cluster;
      logic [LBA_W-1:0] fat_start_lba;
      logic [LBA_W-1:0] data_start_lba;
   } cfg_type;

   typedef struct packed {
      req_kind_type         req_type;
      logic [CLUSTER_W-1:0] cluster;
      logic [BYTES_W-1:0]   byte_limit;
   } item_type;

   typedef struct packed {
      logic                copy_valid;
      logic [LBA_W-1:0]    source_lba;
      logic [COPY_W-1:0]   copy_bytes;
      logic [BYTES_W-1:0]  dest_offset;
      logic [LBA_W-1:0]    fat_entry_lba;
      logic [OFFSET_W-1:0] fat_entry_offset;
      logic                need_next;
      logic                finished;
      logic [BYTES_W-1:0]  total_bytes;
      logic                unexpected_reply;
   } result_type;

endpackage

/* hw/rtl/fcr_csr.sv */
// ----------------------------------------------------------------------------
// FAT16 chain reader configuration registers
// Holds sectors per cluster and the FAT and data region start sectors.
// ----------------------------------------------------------------------------
module fcr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fcr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fcr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output fcr_pkg::cfg_type               cfg
);
   import fcr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Writes to an index outside the register list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SECTORS_PER_CLUSTER: cfg_in.sectors_per_cluster = csr_wdata[SPC_W-1:0];
            CSR_FAT_START_LBA:       cfg_in.fat_start_lba       = csr_wdata[LBA_W-1:0];
            CSR_DATA_START_LBA:      cfg_in.data_start_lba      = csr_wdata[LBA_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sectors_per_cluster <= SPC_W'(1);
         cfg_ff.fat_start_lba       <= '0;
         cfg_ff.data_start_lba      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hw/rtl/fcr_walk_core.sv */
// ----------------------------------------------------------------------------
// FAT16 chain reader walk core
// Walk state and the combinational step that turns one item into one result.
// ----------------------------------------------------------------------------
module fcr_walk_core (
   input  logic                 clock,
   input  logic                 reset,
   input  fcr_pkg::cfg_type     cfg,
   input  fcr_pkg::item_type    item,
   input  logic                 advance,
   output fcr_pkg::result_type  result
);
   import fcr_pkg::*;

   logic [BYTES_W-1:0] bytes_done_ff, bytes_done_in;
   logic [BYTES_W-1:0] limit_bytes_ff, limit_bytes_in;
   logic               awaiting_ff, awaiting_in;

   logic                 is_start;
   logic                 is_stray;
   logic [CLUSTER_W-1:0] clus;
   logic [BYTES_W-1:0]   done_base;
   logic [BYTES_W-1:0]   lim;
   logic                 end_walk;
   logic [CSIZE_W-1:0]   csize_raw;
   logic [COPY_W-1:0]    csize;
   logic [BYTES_W-1:0]   remaining;
   logic [COPY_W-1:0]    want;
   logic [BYTES_W-1:0]   new_done;
   logic                 more;
   logic [CLUSTER_W-1:0] rel_cluster;
   logic [LBA_W-1:0]     src_lba;
   logic [CLUSTER_W:0]   byte_pos;
   logic [LBA_W-1:0]     fat_lba;
   logic [OFFSET_W-1:0]  fat_off;

   assign is_start  = (item.req_type == REQ_START);
   assign is_stray  = !is_start && !awaiting_ff;
   assign clus      = item.cluster;
   assign done_base = is_start ? '0 : bytes_done_ff;
   assign lim       = is_start ? item.byte_limit : limit_bytes_ff;

   assign end_walk = (done_base >= lim) || (clus < FIRST_DATA_CLUSTER) ||
                     (clus >= END_CLUSTER);

   // Cluster size saturates at 64 KiB.
   assign csize_raw = {cfg.sectors_per_cluster, {SECTOR_SHIFT{1'b0}}};
   assign csize     = (csize_raw > CSIZE_W'(MAX_CLUSTER_BYTES)) ?
                      COPY_W'(MAX_CLUSTER_BYTES) : COPY_W'(csize_raw);

   assign remaining = lim - done_base;
   assign want      = (remaining > BYTES_W'(csize)) ? csize : remaining[COPY_W-1:0];
   assign new_done  = done_base + BYTES_W'(want);
   assign more      = (new_done < lim);

   assign rel_cluster = clus - FIRST_DATA_CLUSTER;
   assign src_lba     = cfg.data_start_lba +
                        LBA_W'(rel_cluster) * LBA_W'(cfg.sectors_per_cluster);

   assign byte_pos = {clus, 1'b0};
   assign fat_lba  = cfg.fat_start_lba + LBA_W'(byte_pos >> SECTOR_SHIFT);
   assign fat_off  = OFFSET_W'(byte_pos % SECTOR_BYTES);

   always_comb begin
      result = '0;
      priority if (is_stray) begin
         result.unexpected_reply = 1'b1;
         result.total_bytes      = bytes_done_ff;
      end else if (end_walk) begin
         result.finished    = 1'b1;
         result.total_bytes = done_base;
      end else begin
         result.copy_valid  = 1'b1;
         result.source_lba  = src_lba;
         result.copy_bytes  = want;
         result.dest_offset = done_base;
         result.total_bytes = new_done;
         if (more) begin
            result.need_next        = 1'b1;
            result.fat_entry_lba    = fat_lba;
            result.fat_entry_offset = fat_off;
         end else begin
            result.finished = 1'b1;
         end
      end
   end

   // A stray reply leaves the walk untouched; anything else restarts or advances it.
   always_comb begin
      bytes_done_in  = bytes_done_ff;
      limit_bytes_in = limit_bytes_ff;
      awaiting_in    = awaiting_ff;
      if (advance && !is_stray) begin
         bytes_done_in  = end_walk ? done_base : new_done;
         limit_bytes_in = lim;
         awaiting_in    = !end_walk && more;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_done_ff  <= '0;
         limit_bytes_ff <= '0;
         awaiting_ff    <= 1'b0;
      end else begin
         bytes_done_ff  <= bytes_done_in;
         limit_bytes_ff <= limit_bytes_in;
         awaiting_ff    <= awaiting_in;
      end
   end

`ifndef ASSERT_OFF
   a_need_next_sets_wait: assert property (@(posedge clock) disable iff (reset)
      advance && result.need_next |=> awaiting_ff)
      else $error("reply wait not armed after a FAT entry request");

   a_stray_keeps_state: assert property (@(posedge clock) disable iff (reset)
      advance && result.unexpected_reply |=>
         $stable(bytes_done_ff) && $stable(limit_bytes_ff) && !awaiting_ff)
      else $error("stray reply changed the walk state");

   a_copy_total: assert property (@(posedge clock) disable iff (reset)
      advance && result.copy_valid |->
         result.total_bytes == result.dest_offset + BYTES_W'(result.copy_bytes))
      else $error("running total does not match copy offset plus length");

   a_finish_or_request: assert property (@(posedge clock) disable iff (reset)
      advance && result.copy_valid |-> (result.need_next != result.finished))
      else $error("copy must either request the next entry or finish");
`endif

endmodule

/* hw/rtl/fat16_cluster_chain_reader.sv */
// ----------------------------------------------------------------------------
// FAT16 cluster chain reader
// Plans a read along a FAT16 cluster chain, one copy command per cluster.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one item per transfer. A start (req_type = 0) gives the first
//           cluster and the byte limit; a reply (req_type = 1) gives the FAT
//           entry value fetched after a need_next result.
//   rsp_* : exactly one result per request transfer, in order: a copy
//           command, a FAT entry request (need_next), finished with the
//           running total, or unexpected_reply for a reply with no walk
//           waiting on one.
//   csr_* : register writes, always ready; write only while the block is idle.
// Timing: a request transfer lands in the input register; the result is
//   computed there combinationally and shows up on rsp_* from the result
//   register. One request per cycle is sustained while rsp_ready is high;
//   the walk state (bytes done, pending reply) updates when the result loads.
// Stall: while rsp_ready is low the result register holds and the input
//   register fills; req_ready drops once both are occupied.
// Reset: walk returns to idle, registers return to their reset values
//   (one sector per cluster, both start sectors zero), both stages empty.
module fat16_cluster_chain_reader (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [fcr_pkg::CLUSTER_W-1:0]   req_cluster,
   input  logic [fcr_pkg::BYTES_W-1:0]     req_byte_limit,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_copy_valid,
   output logic [fcr_pkg::LBA_W-1:0]       rsp_source_lba,
   output logic [fcr_pkg::COPY_W-1:0]      rsp_copy_bytes,
   output logic [fcr_pkg::BYTES_W-1:0]     rsp_dest_offset,
   output logic [fcr_pkg::LBA_W-1:0]       rsp_fat_entry_lba,
   output logic [fcr_pkg::OFFSET_W-1:0]    rsp_fat_entry_offset,
   output logic                            rsp_need_next,
   output logic                            rsp_finished,
   output logic [fcr_pkg::BYTES_W-1:0]     rsp_total_bytes,
   output logic                            rsp_unexpected_reply,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fcr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fcr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fcr_pkg::*;

   cfg_type    cfg;

   // Input stage
   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;

   // Result stage
   logic       out_valid_ff, out_valid_in;
   result_type result_ff, result_in;

   result_type step_result;
   logic       advance;
   logic       take_req;

   fcr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fcr_walk_core u_walk (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item_ff),
      .advance (advance),
      .result  (step_result)
   );

   // Advance the held item into the result register when that slot frees up.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (take_req) begin
         in_valid_in        = 1'b1;
         item_in.req_type   = req_kind_type'(req_type);
         item_in.cluster    = req_cluster;
         item_in.byte_limit = req_byte_limit;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         result_in    = step_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_copy_valid       = result_ff.copy_valid;
   assign rsp_source_lba       = result_ff.source_lba;
   assign rsp_copy_bytes       = result_ff.copy_bytes;
   assign rsp_dest_offset      = result_ff.dest_offset;
   assign rsp_fat_entry_lba    = result_ff.fat_entry_lba;
   assign rsp_fat_entry_offset = result_ff.fat_entry_offset;
   assign rsp_need_next        = result_ff.need_next;
   assign rsp_finished         = result_ff.finished;
   assign rsp_total_bytes      = result_ff.total_bytes;
   assign rsp_unexpected_reply = result_ff.unexpected_reply;

`ifndef ASSERT_OFF
   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_need_next, rsp_finished, rsp_unexpected_reply}))
      else $error("result must be exactly one of request, finish or stray reply");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(item_ff))
      else $error("held request lost while the result stage was stalled");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !advance)
      else $error("result register overwritten before its transfer");
`endif

endmodule
